[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and calendar functions of the epoch-to-calendar block.
// ----------------------------------------------------------------------------
package esc_pkg;

    // each division is a reciprocal multiply step followed by a remainder step
    localparam int ESC_DIV_CYC   = 2;
    localparam int ESC_CNT_W     = $clog2(ESC_DIV_CYC);

    localparam int ESC_IN_W      = 31;
    localparam int ESC_DAYS_W    = 15;
    localparam int ESC_YEAR_W    = 11;

    // quotient = (n * ceil(2^s / d)) >> s, exact for every n below 2^31
    localparam int ESC_RCP_W     = 32;
    localparam int ESC_PROD_W    = ESC_IN_W + ESC_RCP_W;
    localparam int ESC_SH_60     = 37;
    localparam int ESC_SH_24     = 36;
    localparam int ESC_SH_7      = 34;
    localparam logic [ESC_RCP_W-1:0] ESC_RCP_60 = 32'd2290649225;
    localparam logic [ESC_RCP_W-1:0] ESC_RCP_24 = 32'd2863311531;
    localparam logic [ESC_RCP_W-1:0] ESC_RCP_7  = 32'd2454267027;

    localparam logic [ESC_YEAR_W-1:0] ESC_EPOCH_YEAR = 11'd1970;
    localparam logic [3:0]            ESC_JAN        = 4'd1;
    localparam logic [3:0]            ESC_FEB        = 4'd2;
    localparam logic [3:0]            ESC_DEC        = 4'd12;

    typedef logic [1:0] t_phase;

    // division phases, in order
    localparam t_phase ESC_PH_SEC  = 2'd0;
    localparam t_phase ESC_PH_MIN  = 2'd1;
    localparam t_phase ESC_PH_HOUR = 2'd2;
    localparam t_phase ESC_PH_WDAY = 2'd3;

    typedef struct packed {
        logic   load_in;
        logic   div_step;
        logic   div_last;
        t_phase div_sel;
        logic   year_step;
        logic   month_step;
        logic   load_out;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_sts;

    function automatic logic [5:0] esc_divisor(input t_phase ph);
        logic [5:0] d;
        case (ph)
            ESC_PH_SEC:  d = 6'd60;
            ESC_PH_MIN:  d = 6'd60;
            ESC_PH_HOUR: d = 6'd24;
            default:     d = 6'd7;
        endcase
        return d;
    endfunction

    function automatic logic [ESC_RCP_W-1:0] esc_recip(input t_phase ph);
        logic [ESC_RCP_W-1:0] r;
        case (ph)
            ESC_PH_HOUR: r = ESC_RCP_24;
            ESC_PH_WDAY: r = ESC_RCP_7;
            default:     r = ESC_RCP_60;
        endcase
        return r;
    endfunction

    function automatic logic esc_is_leap(input logic [ESC_YEAR_W-1:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    function automatic logic [8:0] esc_year_len(input logic [ESC_YEAR_W-1:0] y);
        return esc_is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] esc_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            ESC_FEB:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[sv/esc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_in_if
// Input channel: seconds since the epoch.
// ----------------------------------------------------------------------------
interface esc_in_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::ESC_IN_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[sv/esc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_out_if
// Output channel: broken-down calendar date and time.
// ----------------------------------------------------------------------------
interface esc_out_if;
    logic                           valid;
    logic                           ready;
    logic [5:0]                     sec_of_minute;
    logic [5:0]                     min_of_hour;
    logic [4:0]                     hour_of_day;
    logic [2:0]                     weekday;
    logic [4:0]                     day_of_month;
    logic [3:0]                     month_num;
    logic [esc_pkg::ESC_YEAR_W-1:0] year_num;

    modport source (output valid, output sec_of_minute, output min_of_hour,
                    output hour_of_day, output weekday, output day_of_month,
                    output month_num, output year_num, input ready);
    modport sink   (input valid, input sec_of_minute, input min_of_hour,
                    input hour_of_day, input weekday, input day_of_month,
                    input month_num, input year_num, output ready);
endinterface

[sv/esc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: reciprocal constant divider, year and month walkers, output register.
// ----------------------------------------------------------------------------
module esc_dp (
    input  logic                           i_clk,
    input  esc_pkg::t_cmd                  i_cmd,
    input  logic [esc_pkg::ESC_IN_W-1:0]   i_epoch_seconds,
    output esc_pkg::t_sts                  o_sts,
    output logic [5:0]                     o_sec_of_minute,
    output logic [5:0]                     o_min_of_hour,
    output logic [4:0]                     o_hour_of_day,
    output logic [2:0]                     o_weekday,
    output logic [4:0]                     o_day_of_month,
    output logic [3:0]                     o_month_num,
    output logic [esc_pkg::ESC_YEAR_W-1:0] o_year_num
);

    logic [esc_pkg::ESC_IN_W-1:0]    r_num;
    logic [esc_pkg::ESC_IN_W-1:0]    r_quo;
    logic [5:0]                      r_sec;
    logic [5:0]                      r_min;
    logic [4:0]                      r_hour;
    logic [2:0]                      r_wday;
    logic [esc_pkg::ESC_DAYS_W-1:0]  r_days;
    logic [esc_pkg::ESC_YEAR_W-1:0]  r_year;
    logic [3:0]                      r_month;

    logic [5:0]                      divisor;
    logic [esc_pkg::ESC_PROD_W-1:0]  prod;
    logic [esc_pkg::ESC_IN_W-1:0]    quo;
    logic [5:0]                      rem;
    logic [8:0]                      year_len;
    logic [4:0]                      month_len;
    logic                            year_done;
    logic                            month_done;

    assign divisor = esc_pkg::esc_divisor(i_cmd.div_sel);

    assign prod = esc_pkg::ESC_PROD_W'(r_num)
                * esc_pkg::ESC_PROD_W'(esc_pkg::esc_recip(i_cmd.div_sel));

    always_comb begin
        case (i_cmd.div_sel)
            esc_pkg::ESC_PH_HOUR:
                quo = esc_pkg::ESC_IN_W'(prod[esc_pkg::ESC_PROD_W-1:esc_pkg::ESC_SH_24]);
            esc_pkg::ESC_PH_WDAY:
                quo = esc_pkg::ESC_IN_W'(prod[esc_pkg::ESC_PROD_W-1:esc_pkg::ESC_SH_7]);
            default:
                quo = esc_pkg::ESC_IN_W'(prod[esc_pkg::ESC_PROD_W-1:esc_pkg::ESC_SH_60]);
        endcase
    end

    // remainder is below 64, so the low six bits suffice
    assign rem = r_num[5:0] - 6'(r_quo[5:0] * divisor);

    assign year_len   = esc_pkg::esc_year_len(r_year);
    assign month_len  = esc_pkg::esc_month_len(r_month, esc_pkg::esc_is_leap(r_year));
    assign year_done  = (r_days < esc_pkg::ESC_DAYS_W'(year_len));
    assign month_done = (r_month == esc_pkg::ESC_DEC)
                     || (r_days < esc_pkg::ESC_DAYS_W'(month_len));

    assign o_sts.year_done  = year_done;
    assign o_sts.month_done = month_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_num   <= i_epoch_seconds;
            r_year  <= esc_pkg::ESC_EPOCH_YEAR;
            r_month <= esc_pkg::ESC_JAN;
        end else if (i_cmd.div_step) begin
            if (i_cmd.div_last) begin
                // quotient becomes the next dividend, remainder lands in its field
                r_num <= r_quo;
                case (i_cmd.div_sel)
                    esc_pkg::ESC_PH_SEC:  r_sec  <= rem;
                    esc_pkg::ESC_PH_MIN:  r_min  <= rem;
                    esc_pkg::ESC_PH_HOUR: begin
                        r_hour <= rem[4:0];
                        r_days <= r_quo[esc_pkg::ESC_DAYS_W-1:0];
                    end
                    default:              r_wday <= rem[2:0];
                endcase
            end else begin
                r_quo <= quo;
            end
        end

        if (i_cmd.year_step && !year_done) begin
            r_days <= r_days - esc_pkg::ESC_DAYS_W'(year_len);
            r_year <= r_year + 1'b1;
        end

        if (i_cmd.month_step && !month_done) begin
            r_days  <= r_days - esc_pkg::ESC_DAYS_W'(month_len);
            r_month <= r_month + 1'b1;
        end

        if (i_cmd.load_out) begin
            o_sec_of_minute <= r_sec;
            o_min_of_hour   <= r_min;
            o_hour_of_day   <= r_hour;
            o_weekday       <= r_wday;
            o_day_of_month  <= r_days[4:0] + 1'b1;
            o_month_num     <= r_month;
            o_year_num      <= r_year;
        end
    end

endmodule

[sv/esc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Controller: sequences the four divisions, the year walk and the month walk.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  esc_pkg::t_sts i_sts,
    output esc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_YEAR  = 3'd2;
    localparam logic [2:0] S_MONTH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [esc_pkg::ESC_CNT_W-1:0] CNT_LAST =
        esc_pkg::ESC_CNT_W'(esc_pkg::ESC_DIV_CYC - 1);

    logic [2:0]                      r_state, n_state;
    logic [esc_pkg::ESC_CNT_W-1:0]   r_cnt,   n_cnt;
    esc_pkg::t_phase                 r_phase, n_phase;
    logic                            r_out_valid, n_out_valid;
    esc_pkg::t_cmd                   cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        cmd         = '0;
        cmd.div_sel = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_cnt       = '0;
                    n_phase     = esc_pkg::ESC_PH_SEC;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    cmd.div_last = 1'b1;
                    n_cnt        = '0;
                    if (r_phase == esc_pkg::ESC_PH_WDAY) begin
                        n_state = S_YEAR;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_YEAR: begin
                cmd.year_step = 1'b1;
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                cmd.month_step = 1'b1;
                if (i_sts.month_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_phase     <= esc_pkg::ESC_PH_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[sv/epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 into a broken-down calendar date.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  i_in     in   epoch_seconds[30:0]
//  o_out    out  sec_of_minute, min_of_hour, hour_of_day, weekday,
//                day_of_month, month_num, year_num
//
//  One item passes through four divisions by constants, each a reciprocal
//  multiply step followed by a remainder step, then a year walk that steps
//  once per elapsed year and a month walk that steps once per elapsed month.
//  One item is in flight; the result sits in an output register, so the next
//  item is taken while an earlier result waits, and its final state stalls
//  until that register is free. Reset is synchronous, active low, and clears
//  only control state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esc_in_if.sink     i_in,
    esc_out_if.source  o_out
);

    esc_pkg::t_cmd cmd;
    esc_pkg::t_sts sts;

    esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    esc_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_epoch_seconds (i_in.epoch_seconds),
        .o_sts           (sts),
        .o_sec_of_minute (o_out.sec_of_minute),
        .o_min_of_hour   (o_out.min_of_hour),
        .o_hour_of_day   (o_out.hour_of_day),
        .o_weekday       (o_out.weekday),
        .o_day_of_month  (o_out.day_of_month),
        .o_month_num     (o_out.month_num),
        .o_year_num      (o_out.year_num)
    );

    `ESC_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready after accept")
    `ESC_ASSERT_NOW(a_month_range, o_out.valid, o_out.month_num >= 4'd1 && o_out.month_num <= 4'd12, "month out of range")
    `ESC_ASSERT_NOW(a_day_week_range, o_out.valid, o_out.day_of_month != 5'd0 && o_out.weekday != 3'd7, "day or weekday out of range")
    `ESC_ASSERT_NOW(a_time_range, o_out.valid, o_out.sec_of_minute < 6'd60 && o_out.hour_of_day < 5'd24, "time field out of range")

endmodule

[bench/tb_epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Drives epoch second counts into the converter and checks every calendar
// result against a date computed in the bench. Directed time of day, month,
// year and leap day boundaries and bit patterns come first, then random counts
// and boundaries. Both sides stall at random, and the run includes one long
// output stall and one pause on the input side that waits for every result.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned DRAIN_AT     = 260;   // sender waits for all results here
    localparam int unsigned HOLD_AT      = 120;   // receiver stalls long after this many
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 150;
    localparam logic [3:0]  APR          = 4'd4;
    localparam logic [3:0]  JUN          = 4'd6;
    localparam logic [3:0]  SEP          = 4'd9;
    localparam logic [3:0]  NOV          = 4'd11;

    typedef struct packed {
        logic [5:0]                     sec_of_minute;
        logic [5:0]                     min_of_hour;
        logic [4:0]                     hour_of_day;
        logic [2:0]                     weekday;
        logic [4:0]                     day_of_month;
        logic [3:0]                     month_num;
        logic [esc_pkg::ESC_YEAR_W-1:0] year_num;
    } t_date;

    logic i_clk;
    logic i_rst_n;

    esc_in_if  in_ch ();
    esc_out_if out_ch ();

    epoch_seconds_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [esc_pkg::ESC_IN_W-1:0] pending_secs [$];
    t_date                        expected_dates [$];
    logic                         in_fire;
    logic                         out_fire;
    int unsigned                  fail_count;
    int unsigned                  items_sent;
    int unsigned                  results_seen;
    int unsigned                  tx_gap;
    int unsigned                  rx_gap;
    int unsigned                  rx_hold_left;
    bit                           rx_hold_done;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned days_in_year(input int unsigned yr);
        return (yr % 4 == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input logic [3:0] mo,
                                                  input int unsigned yr);
        if (mo == esc_pkg::ESC_FEB)
            return (yr % 4 == 0) ? 29 : 28;
        if (mo == APR || mo == JUN || mo == SEP || mo == NOV)
            return 30;
        return 31;
    endfunction

    // Seconds at midnight on the first day of the given month.
    function automatic longint month_start_secs(input int unsigned yr, input int unsigned mo);
        longint d;
        d = 0;
        for (int unsigned y = 32'(esc_pkg::ESC_EPOCH_YEAR); y < yr; y++)
            d += days_in_year(y);
        for (int unsigned m = 32'(esc_pkg::ESC_JAN); m < mo; m++)
            d += days_in_month(m[3:0], yr);
        return d * SECS_PER_DAY;
    endfunction

    function automatic t_date calendar_of(input logic [esc_pkg::ESC_IN_W-1:0] secs);
        t_date       d;
        int unsigned t;
        int unsigned day_cnt;
        int unsigned yr;
        int unsigned mo;
        t = 32'(secs);
        d.sec_of_minute = 6'(t % 60);
        t = t / 60;
        d.min_of_hour = 6'(t % 60);
        t = t / 60;
        d.hour_of_day = 5'(t % 24);
        day_cnt = t / 24;
        d.weekday = 3'(day_cnt % 7);
        yr = 32'(esc_pkg::ESC_EPOCH_YEAR);
        while (day_cnt >= days_in_year(yr)) begin
            day_cnt -= days_in_year(yr);
            yr++;
        end
        // the last day of a month stays in that month; December never rolls past 12
        mo = 32'(esc_pkg::ESC_JAN);
        while (mo < 32'(esc_pkg::ESC_DEC) && day_cnt >= days_in_month(mo[3:0], yr)) begin
            day_cnt -= days_in_month(mo[3:0], yr);
            mo++;
        end
        d.day_of_month = 5'(day_cnt + 1);
        d.month_num    = 4'(mo);
        d.year_num     = esc_pkg::ESC_YEAR_W'(yr);
        return d;
    endfunction

    // Mostly short gaps, a few long ones; every fourth run of 16 transfers has none.
    function automatic int unsigned pick_gap(input int unsigned seq);
        int unsigned r;
        if ((seq / 16) % 4 == 3)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Record transfers on both channels and check results.
    always @(posedge i_clk) begin
        t_date want;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= in_ch.valid && in_ch.ready;
            out_fire <= out_ch.valid && out_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_dates.push_back(calendar_of(in_ch.epoch_seconds));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_dates.size() == 0) begin
                    $error("result with no input pending");
                    fail_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("sec_of_minute", 32'(want.sec_of_minute),
                                32'(out_ch.sec_of_minute));
                    check_field("min_of_hour", 32'(want.min_of_hour),
                                32'(out_ch.min_of_hour));
                    check_field("hour_of_day", 32'(want.hour_of_day),
                                32'(out_ch.hour_of_day));
                    check_field("weekday", 32'(want.weekday), 32'(out_ch.weekday));
                    check_field("day_of_month", 32'(want.day_of_month),
                                32'(out_ch.day_of_month));
                    check_field("month_num", 32'(want.month_num), 32'(out_ch.month_num));
                    check_field("year_num", 32'(want.year_num), 32'(out_ch.year_num));
                end
                results_seen++;
            end
        end
    end

    // Input driver: hold an offered item until its transfer, then maybe idle.
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && !in_fire)) begin
            if (in_fire)
                tx_gap = pick_gap(items_sent);
            if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (items_sent == DRAIN_AT && expected_dates.size() != 0) begin
                in_ch.valid <= 1'b0;
            end else if (pending_secs.size() != 0) begin
                in_ch.valid         <= 1'b1;
                in_ch.epoch_seconds <= pending_secs.pop_front();
                items_sent++;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output side: random ready gaps plus one long stall to back up the block.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!rx_hold_done && results_seen >= HOLD_AT) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (out_fire)
                    rx_gap = pick_gap(results_seen);
                if (rx_gap > 0) begin
                    rx_gap--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("epoch_seconds_to_calendar verification failed");
        $finish;
    end

    initial begin
        int unsigned r;
        int unsigned yr;
        int unsigned mo;
        longint      s;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.epoch_seconds = '0;
        out_ch.ready        = 1'b0;
        fail_count          = 0;
        items_sent          = 0;
        results_seen        = 0;
        tx_gap              = 0;
        rx_gap              = 0;
        rx_hold_left        = 0;
        rx_hold_done        = 1'b0;

        // time of day rollovers and the end of the first week
        pending_secs.push_back(31'd0);
        pending_secs.push_back(31'd59);
        pending_secs.push_back(31'd60);
        pending_secs.push_back(31'd3599);
        pending_secs.push_back(31'd3600);
        pending_secs.push_back(31'd86399);
        pending_secs.push_back(31'd86400);
        pending_secs.push_back(31'(7 * SECS_PER_DAY - 1));
        // last second of a month and first second of the next, leap day included
        s = month_start_secs(1970, 2);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        s = month_start_secs(1970, 3);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        s = month_start_secs(1971, 1);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        s = month_start_secs(1972, 3);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        s = month_start_secs(1973, 1);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        s = month_start_secs(2038, 1);
        pending_secs.push_back(31'(s - 1));
        pending_secs.push_back(31'(s));
        // largest count and alternating bit patterns
        pending_secs.push_back(31'h7FFF_FFFF);
        pending_secs.push_back(31'h2AAA_AAAA);
        pending_secs.push_back(31'h5555_5555);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                pending_secs.push_back(31'($urandom()));
            end else if (r < 90) begin
                yr = $urandom_range(1970, 2037);
                mo = $urandom_range(1, 12);
                s  = month_start_secs(yr, mo) + $urandom_range(0, 6) - 3;
                if (s < 0)
                    s = 0;
                pending_secs.push_back(31'(s));
            end else begin
                pending_secs.push_back(31'($urandom_range(0, 200000)));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_secs.size() != 0 || in_ch.valid || expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("epoch_seconds_to_calendar verification clean");
        else
            $display("epoch_seconds_to_calendar verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/esc_pkg.sv
sv/esc_in_if.sv
sv/esc_out_if.sv
sv/esc_dp.sv
sv/esc_ctrl.sv
sv/epoch_seconds_to_calendar.sv
bench/tb_epoch_seconds_to_calendar.sv
